// ===== design/multichannel_scan_direction_generator_unit_defines.svh =====
// assertion macros for the scan direction generator
`ifndef MULTICHANNEL_SCAN_DIRECTION_GENERATOR_UNIT_DEFINES_SVH
`define MULTICHANNEL_SCAN_DIRECTION_GENERATOR_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define MSDG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked every clock outside reset
`define MSDG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/msdg_pkg.sv =====
package msdg_pkg;

   localparam int CHANNELS_DEF   = 16;
   localparam int MAX_POINTS_DEF = 4;

   localparam int TURN      = 46080;
   localparam int HALF_TURN = 23040;

   // period numerator scale and division widths
   localparam int NUM_W = 36;   // step * 1000000 < 2^36
   localparam int DEN_W = 13;   // 3 * rpm < 2^13
   localparam int T_W   = 40;   // time with 8 fraction bits
   localparam int FR_W  = 17;

   localparam logic [1:0] CSR_STEP   = 2'd0;
   localparam logic [1:0] CSR_RPM    = 2'd1;
   localparam logic [1:0] CSR_CHANS  = 2'd2;
   localparam logic [1:0] CSR_OFFSET = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PERIOD,
      ST_COUNT,
      ST_FRAC,
      ST_EMIT
   } state_type;

   // control between sequencer and serial divider
   typedef struct packed {
      logic              start;
      logic [T_W+16-1:0] dividend;
      logic [T_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [T_W+16-1:0] quotient;
   } div_rsp_type;

   // wraps a value within (-2*TURN, 2*TURN) into (-HALF_TURN, HALF_TURN]
   function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] v);
      logic signed [17:0] r;
      r = v;
      if (r > 18'sd23040) r = r - 18'sd46080;
      if (r > 18'sd23040) r = r - 18'sd46080;
      if (r <= -18'sd23040) r = r + 18'sd46080;
      if (r <= -18'sd23040) r = r + 18'sd46080;
      return r;
   endfunction

endpackage

// ===== design/msdg_if.sv =====
interface msdg_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [3:0]  channel_index;
   logic signed [15:0] vertical_angle;
   logic signed [15:0] horizontal_offset;
   logic [31:0] current_time;
   modport source (output valid, action, channel_index, vertical_angle,
                   horizontal_offset, current_time, input ready);
   modport sink (input valid, action, channel_index, vertical_angle,
                 horizontal_offset, current_time, output ready);
endinterface

interface msdg_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] pitch;
   logic signed [15:0] yaw_angle;
   logic [16:0] time_fraction;
   logic [3:0]  out_channel;
   logic [31:0] scan_time;
   logic        saturated;
   logic        last;
   modport source (output valid, pitch, yaw_angle, time_fraction, out_channel,
                   scan_time, saturated, last, input ready);
   modport sink (input valid, pitch, yaw_angle, time_fraction, out_channel,
                 scan_time, saturated, last, output ready);
endinterface

interface msdg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/multichannel_scan_direction_generator_unit.sv =====
// a load request writes the channel table; a time request runs serial divisions (period,
//   point count, then one fraction per point); up to MAX_POINTS * CHANNELS results, one per
//   cycle while rsp.ready is high, each point's results following its fraction division
// a time request with no whole point elapsed ends after the count division, with no results
// throughput: one request at a time
// reset: synchronous, active high; state, yaw, last time and CSRs reset, tables read zero
`include "multichannel_scan_direction_generator_unit_defines.svh"
module multichannel_scan_direction_generator_unit
   import msdg_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   msdg_req_if.sink   req,
   msdg_rsp_if.source rsp,
   msdg_csr_if.sink   csr
);
   localparam int PW = $clog2(MAX_POINTS + 1);
   localparam int QW = T_W + 16;

   state_type state_ff, state_in;

   logic [15:0] step_ff;
   logic [10:0] rpm_ff;
   logic [4:0]  chans_ff;
   logic        offen_ff;

   logic signed [15:0] yaw_ff, yaw_in;
   logic [T_W-1:0] last_ff, last_in;
   logic [T_W-1:0] end_ff, end_in;   // last time after this update
   logic [T_W-1:0] per_ff, per_in;
   logic [T_W-1:0] dur_ff, dur_in;
   logic [PW-1:0]  npts_ff, npts_in;
   logic [PW-1:0]  pt_ff, pt_in;
   logic [3:0]     ch_ff, ch_in;
   logic           sat_ff, sat_in;
   logic [T_W-1:0] acc_ff, acc_in;   // i * period
   logic signed [17:0] base_ff, base_in;
   logic [FR_W-1:0] frac_ff, frac_in;
   logic [4:0]     nch;

   div_req_type dreq;
   div_rsp_type drsp;

   logic               tbl_wr;
   logic signed [15:0] tv, to;
   logic signed [17:0] yaw_sum;
   logic signed [17:0] yaw_wrap;
   logic               cnt_over;
   logic [PW-1:0]      cnt_sat;
   logic [T_W-1:0]     pts_span;

   msdg_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   msdg_table #(.CHANNELS(CHANNELS)) u_tbl (
      .clock(clock), .reset(reset),
      .wr_en(tbl_wr), .wr_idx(req.channel_index),
      .wr_vert(req.vertical_angle), .wr_off(req.horizontal_offset),
      .rd_idx(ch_ff), .rd_vert(tv), .rd_off(to)
   );

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 16'd128;
         rpm_ff   <= 11'd600;
         chans_ff <= 5'd16;
         offen_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_STEP:   step_ff  <= csr.data;
            CSR_RPM:    rpm_ff   <= csr.data[10:0];
            CSR_CHANS:  chans_ff <= csr.data[4:0];
            CSR_OFFSET: offen_ff <= csr.data[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      if (chans_ff == 5'd0) nch = 5'd1;
      else if (32'(chans_ff) > CHANNELS) nch = 5'(CHANNELS);
      else nch = chans_ff;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign tbl_wr    = req.valid && req.ready && !req.action;

   assign yaw_sum  = base_ff + (offen_ff ? 18'(to) : 18'sd0);
   assign yaw_wrap = wrap_angle(yaw_sum);

   // point count limited to MAX_POINTS, and its span as shift and add
   assign cnt_over = (drsp.quotient > QW'(MAX_POINTS));
   assign cnt_sat  = cnt_over ? PW'(MAX_POINTS) : drsp.quotient[PW-1:0];

   always_comb begin
      pts_span = '0;
      for (int k = 0; k < PW; k++) begin
         if (cnt_sat[k]) pts_span = pts_span + (per_ff << k);
      end
   end

   always_comb begin
      state_in = state_ff;
      yaw_in   = yaw_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      per_in   = per_ff;
      dur_in   = dur_ff;
      npts_in  = npts_ff;
      pt_in    = pt_ff;
      ch_in    = ch_ff;
      sat_in   = sat_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      frac_in  = frac_ff;
      dreq.start    = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = '1;
      rsp.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.action) begin
               dur_in = {req.current_time, 8'd0} - last_ff;
               dreq.start    = 1'b1;
               dreq.dividend = QW'(36'(step_ff) * 36'd1000000);
               dreq.divisor  = T_W'(13'(rpm_ff == 11'd0 ? 11'd1 : rpm_ff) * 13'd3);
               state_in = ST_PERIOD;
            end
         end
         ST_PERIOD: begin
            if (drsp.done) begin
               per_in = (drsp.quotient == '0) ? T_W'(1) : drsp.quotient[T_W-1:0];
               dreq.start    = 1'b1;
               dreq.dividend = QW'(dur_ff);
               dreq.divisor  = (drsp.quotient == '0) ? T_W'(1) : drsp.quotient[T_W-1:0];
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (drsp.done) begin
               npts_in = cnt_sat;
               sat_in  = cnt_over;
               end_in  = last_ff + pts_span;
               if (drsp.quotient == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pt_in  = PW'(1);
                  acc_in = per_ff;
                  dreq.start    = 1'b1;
                  dreq.dividend = {per_ff, 16'd0};
                  dreq.divisor  = dur_ff;
                  state_in = ST_FRAC;
               end
            end
         end
         ST_FRAC: begin
            if (drsp.done) begin
               frac_in = drsp.quotient[FR_W-1:0];
               base_in = wrap_angle(18'(yaw_ff) + 18'(step_ff));
               ch_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               if (5'(ch_ff) + 5'd1 == nch) begin
                  yaw_in = base_ff[15:0];
                  if (pt_ff == npts_ff) begin
                     last_in  = end_ff;
                     state_in = ST_IDLE;
                  end else begin
                     pt_in  = pt_ff + 1'b1;
                     acc_in = acc_ff + per_ff;
                     dreq.start    = 1'b1;
                     dreq.dividend = {acc_ff + per_ff, 16'd0};
                     dreq.divisor  = dur_ff;
                     state_in = ST_FRAC;
                  end
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.pitch         = tv;
   assign rsp.yaw_angle     = yaw_wrap[15:0];
   assign rsp.time_fraction = frac_ff;
   assign rsp.out_channel   = ch_ff;
   assign rsp.scan_time     = end_ff[T_W-1:8];
   assign rsp.saturated     = sat_ff;
   assign rsp.last          = (pt_ff == npts_ff) && (5'(ch_ff) + 5'd1 == nch);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         yaw_ff   <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         yaw_ff   <= yaw_in;
         last_ff  <= last_in;
      end
      end_ff  <= end_in;
      per_ff  <= per_in;
      dur_ff  <= dur_in;
      npts_ff <= npts_in;
      pt_ff   <= pt_in;
      ch_ff   <= ch_in;
      sat_ff  <= sat_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      frac_ff <= frac_in;
   end

   `MSDG_ASSERT_IMPL(a_ready_idle, req.ready, state_ff == ST_IDLE, "ready outside idle")
   `MSDG_ASSERT_IMPL(a_valid_emit, rsp.valid, state_ff == ST_EMIT, "result outside emit")
   `MSDG_ASSERT_NEXT(a_stall_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(ch_ff), "stall")
endmodule

// ===== design/msdg_div.sv =====
// restoring divider, one quotient bit per cycle while busy
module msdg_div
   import msdg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int QW = T_W + 16;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0]  quo_ff, quo_in;
   logic [T_W:0]   rem_ff, rem_in;
   logic [T_W-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [T_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[T_W-1:0], quo_ff[QW-1]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ===== design/msdg_table.sv =====
// channel tables with per-entry valid bits, zero until loaded
module msdg_table
   import msdg_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [3:0]         wr_idx,
   input  logic signed [15:0] wr_vert,
   input  logic signed [15:0] wr_off,
   input  logic [3:0]         rd_idx,
   output logic signed [15:0] rd_vert,
   output logic signed [15:0] rd_off
);
   logic signed [15:0] vert_ff [CHANNELS];
   logic signed [15:0] off_ff  [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en && 32'(wr_idx) < CHANNELS) begin
         vld_ff[wr_idx] <= 1'b1;
      end
      if (wr_en && 32'(wr_idx) < CHANNELS) begin
         vert_ff[wr_idx] <= wr_vert;
         off_ff[wr_idx]  <= wr_off;
      end
   end

   always_comb begin
      rd_vert = '0;
      rd_off  = '0;
      if (32'(rd_idx) < CHANNELS && vld_ff[rd_idx]) begin
         rd_vert = vert_ff[rd_idx];
         rd_off  = off_ff[rd_idx];
      end
   end
endmodule
